// ----- hdl/cfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and codes of the contiguous frame allocator
// Request codes, result status codes and the occupancy update control group.
// ----------------------------------------------------------------------------
package cfa_pkg;

  localparam int REQ_W    = 2;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int START_W  = 5;

  // request codes carried in req_type
  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_FREE_RUN = 2'd1,
    REQ_OCCUPY   = 2'd2,
    REQ_FREE_ONE = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_POS  = 2'd2
  } status_t;

  // broadcast update to the slot cells: write enable and the value to write
  typedef struct packed {
    logic en;
    logic set;
  } upd_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/cfa_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_in_if: request channel of the contiguous frame allocator
// Valid/ready handshake carrying one request per transaction.
// ----------------------------------------------------------------------------
interface cfa_in_if;
  import cfa_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] position;

  modport source (output valid, output req_type, output position, input ready);
  modport sink   (input valid, input req_type, input position, output ready);
endinterface
`default_nettype wire

// ----- hdl/cfa_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_out_if: result channel of the contiguous frame allocator
// Valid/ready handshake carrying one result per transaction.
// ----------------------------------------------------------------------------
interface cfa_out_if;
  import cfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_index;
  logic                page_valid;

  modport source (output valid, output status, output start_index, output page_valid,
                  input ready);
  modport sink   (input valid, input status, input start_index, input page_valid,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/cfa_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfa_cell: one slot of the allocator chain
// Holds the occupancy bit of one slot. A scan token passes through one cell
// per cycle, counting consecutive free slots; the first cell that completes a
// free run stamps the run start into the token. Range updates are broadcast.
// ----------------------------------------------------------------------------
module cfa_cell
  import cfa_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int RUN_LENGTH = 3,
  parameter int CNT_W      = 2,
  parameter int RW         = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // broadcast occupancy update over slots upd_lo..upd_hi
  input  wire upd_ctl_t         upd,
  input  wire logic [RW-1:0]    upd_lo,
  input  wire logic [RW-1:0]    upd_hi,
  // scan token from the left neighbour
  input  wire logic             tk_in_valid,
  input  wire logic             tk_in_found,
  input  wire logic [CNT_W-1:0] tk_in_cnt,
  input  wire logic [RW-1:0]    tk_in_start,
  // scan token to the right neighbour
  output logic                  tk_out_valid,
  output logic                  tk_out_found,
  output logic [CNT_W-1:0]      tk_out_cnt,
  output logic [RW-1:0]         tk_out_start
);

  localparam int              START_I = (IDX + 1 >= RUN_LENGTH) ? IDX + 1 - RUN_LENGTH : 0;
  localparam logic [RW-1:0]   IDX_V   = RW'(IDX);
  localparam logic [RW-1:0]   START_V = RW'(START_I);
  localparam logic [CNT_W-1:0] RUN_V  = CNT_W'(RUN_LENGTH);

  logic             occ_r;
  logic             tk_valid_r;
  logic             tk_found_r;
  logic [CNT_W-1:0] tk_cnt_r;
  logic [RW-1:0]    tk_start_r;

  logic [CNT_W-1:0] cnt_inc;
  logic             hit;
  logic             in_rng;

  // run counting: this slot free extends the run, the first full run wins
  always_comb begin
    cnt_inc = tk_in_cnt + CNT_W'(1);
    hit     = tk_in_valid && !tk_in_found && !occ_r && (cnt_inc == RUN_V);
    in_rng  = (IDX_V >= upd_lo) && (IDX_V <= upd_hi);
  end

  // occupancy bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (upd.en && in_rng) begin
      occ_r <= upd.set;
    end
  end

  // token stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tk_valid_r <= 1'b0;
    end else begin
      tk_valid_r <= tk_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    tk_found_r <= tk_in_found | hit;
    tk_cnt_r   <= occ_r ? '0 : cnt_inc;
    tk_start_r <= hit ? START_V : tk_in_start;
  end

  assign tk_out_valid = tk_valid_r;
  assign tk_out_found = tk_found_r;
  assign tk_out_cnt   = tk_cnt_r;
  assign tk_out_start = tk_start_r;

endmodule
`default_nettype wire

// ----- hdl/contiguous_frame_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_frame_allocator: first-fit allocator of runs of free slots
// Occupancy bitmap held in a chain of slot cells, searched by a travelling
// scan token; frees and single-slot writes are applied by broadcast.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_ch     sink       valid / ready      req_type, position
//  out_ch    source     valid / ready      status, start_index, page_valid
//
//  Free-run, occupy and free-slot requests: result registered at acceptance.
//  Allocate: the scan token walks the chain one cell per cycle, then the run
//  is marked and the result registered once the output is free. One request
//  at a time; a new request is taken once the previous result has
//  left or is leaving the output register. Reset clears every slot to free.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator
  import cfa_pkg::*;
#(
  parameter int NUM_SLOTS  = 32,
  parameter int RUN_LENGTH = 3
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cfa_in_if.sink     in_ch,
  cfa_out_if.source  out_ch
);

  localparam int RANGE_TOP = ((NUM_SLOTS > 32) ? NUM_SLOTS : 32) + RUN_LENGTH;
  localparam int RW        = $clog2(RANGE_TOP);
  localparam int CNT_W     = $clog2(RUN_LENGTH + 1);

  localparam logic [RW-1:0] NUM_V    = RW'(NUM_SLOTS);
  localparam logic [RW-1:0] RUN_M1_V = RW'(RUN_LENGTH - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // token chain; entry 0 is the injection point
  logic [NUM_SLOTS:0] tk_valid;
  logic [NUM_SLOTS:0] tk_found;
  logic [CNT_W-1:0]   tk_cnt   [NUM_SLOTS+1];
  logic [RW-1:0]      tk_start [NUM_SLOTS+1];

  upd_ctl_t      upd;
  logic [RW-1:0] upd_lo;
  logic [RW-1:0] upd_hi;

  logic          found_r;
  logic [RW-1:0] run_start_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [START_W-1:0]  start_index_r;
  logic                page_valid_r;

  req_t          req;
  logic [RW-1:0] pos_ext;
  logic          bad_pos;
  logic          out_free;
  logic          accept;
  logic          finish;

  // handshake
  always_comb begin
    req      = req_t'(in_ch.req_type);
    pos_ext  = RW'(in_ch.position);
    bad_pos  = (pos_ext >= NUM_V);
    out_free = !out_valid_r || out_ch.ready;
    accept   = in_ch.valid && in_ch.ready;
    finish   = (state_r == S_FINISH) && out_free;
  end

  assign in_ch.ready = (state_r == S_IDLE) && out_free;

  // token injection
  assign tk_valid[0] = accept && (req == REQ_ALLOC);
  assign tk_found[0] = 1'b0;
  assign tk_cnt[0]   = '0;
  assign tk_start[0] = '0;

  // slot chain
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    cfa_cell #(
      .IDX        (g),
      .RUN_LENGTH (RUN_LENGTH),
      .CNT_W      (CNT_W),
      .RW         (RW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .upd          (upd),
      .upd_lo       (upd_lo),
      .upd_hi       (upd_hi),
      .tk_in_valid  (tk_valid[g]),
      .tk_in_found  (tk_found[g]),
      .tk_in_cnt    (tk_cnt[g]),
      .tk_in_start  (tk_start[g]),
      .tk_out_valid (tk_valid[g+1]),
      .tk_out_found (tk_found[g+1]),
      .tk_out_cnt   (tk_cnt[g+1]),
      .tk_out_start (tk_start[g+1])
    );
  end

  // broadcast update: direct requests at acceptance, run marking at finish
  always_comb begin
    upd.en  = 1'b0;
    upd.set = 1'b0;
    upd_lo  = pos_ext;
    upd_hi  = pos_ext;
    if (finish) begin
      upd.en  = found_r;
      upd.set = 1'b1;
      upd_lo  = run_start_r;
      upd_hi  = run_start_r + RUN_M1_V;
    end else if (accept && !bad_pos) begin
      case (req)
        REQ_FREE_RUN: begin
          upd.en = 1'b1;
          upd_hi = pos_ext + RUN_M1_V;
        end
        REQ_OCCUPY: begin
          upd.en  = 1'b1;
          upd.set = 1'b1;
        end
        REQ_FREE_ONE: begin
          upd.en = 1'b1;
        end
        default: begin
          upd.en = 1'b0;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (req == REQ_ALLOC)) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (tk_valid[NUM_SLOTS]) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // scan outcome capture
  always_ff @(posedge clk) begin
    if ((state_r == S_SCAN) && tk_valid[NUM_SLOTS]) begin
      found_r     <= tk_found[NUM_SLOTS];
      run_start_r <= tk_start[NUM_SLOTS];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((accept && (req != REQ_ALLOC)) || finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      status_r      <= found_r ? ST_DONE : ST_NO_SPACE;
      start_index_r <= found_r ? run_start_r[START_W-1:0] : '0;
      page_valid_r  <= 1'b0;
    end else if (accept && (req != REQ_ALLOC)) begin
      status_r      <= bad_pos ? ST_BAD_POS : ST_DONE;
      start_index_r <= '0;
      page_valid_r  <= !bad_pos && (req == REQ_OCCUPY);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.start_index = start_index_r;
  assign out_ch.page_valid  = page_valid_r;

endmodule
`default_nettype wire
